@@ src/ctsp_pkg.sv @@
`default_nettype none

package ctsp_pkg;

  localparam int unsigned NumCounters = 8;
  localparam int unsigned CountW      = 32;
  localparam int unsigned PctW        = 7;
  localparam int unsigned IdxW        = $clog2(NumCounters);

  // 100 * delta needs 7 more bits than the delta itself
  localparam int unsigned ProdW       = CountW + PctW;
  // one quotient bit beyond the share width flags an oversized quotient
  localparam int unsigned QuotW       = PctW + 1;
  localparam int unsigned QuotCntW    = $clog2(QuotW);

  localparam logic [PctW-1:0] PctFull = PctW'(100);

  localparam int unsigned InDataW     = NumCounters * CountW;
  localparam int unsigned OutDataW    = NumCounters * PctW + CountW;

endpackage

`default_nettype wire

@@ src/ctsp_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Result is floor(dividend / divisor) saturated at PctFull.
module ctsp_div
  import ctsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ProdW-1:0] dividend_i,
  input  wire logic [CountW-1:0] divisor_i,
  output logic                  done_o,
  output logic [PctW-1:0]       quot_o
);

  logic                busy_q;
  logic                done_q;
  logic [QuotCntW-1:0] cnt_q;
  logic [ProdW-1:0]    rem_q;
  logic [ProdW-1:0]    sd_q;
  logic [QuotW-1:0]    quo_q;
  logic [PctW-1:0]     res_q;

  logic             ge;
  logic [QuotW-1:0] quo_d;

  assign ge    = (rem_q >= sd_q);
  assign quo_d = {quo_q[QuotW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QuotCntW'(QuotW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      sd_q  <= {divisor_i, (ProdW - CountW)'(0)};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - sd_q;
      end
      sd_q  <= sd_q >> 1;
      quo_q <= quo_d;
      if (cnt_q == '0) begin
        // clamp: top bit set or low bits above full scale
        if (quo_d[QuotW-1] || (quo_d[PctW-1:0] > PctFull)) begin
          res_q <= PctFull;
        end else begin
          res_q <= quo_d[PctW-1:0];
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

`default_nettype wire

@@ src/cpu_time_share_percent.sv @@
`default_nettype none
// An input beat is summed in 8 summing steps; unless it is the first sample or the total is
// zero, each counter in turn is then scaled by 100 and divided in the shared divider.
// s_axis_tready is low while a sample is in work, so no new sample is taken until it is done.
// A finished result waits in the output register while the next sample is taken.
// Reset (rst_ni, asynchronous, active low) forgets the previous sample and drops any result.
module cpu_time_share_percent
  import ctsp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // user, nice, system, idle, iowait, hardirq, softirq, steal counts (32 bits each)
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // user, nice, system, idle, iowait, hardirq, softirq, steal pct (7 bits each),
  // interval_total (32 bits)
  output logic [OutDataW-1:0]      m_axis_tdata,
  // first_sample
  output logic                     m_axis_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_MUL,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   have_prev_q;
  logic   first_q;
  logic   m_valid_q;
  logic [IdxW-1:0] k_q;

  logic [NumCounters-1:0][CountW-1:0] prev_q;
  logic [NumCounters-1:0][CountW-1:0] delta_q;
  logic [NumCounters-1:0][PctW-1:0]   pct_q;
  logic [CountW-1:0]   total_q;
  logic [ProdW-1:0]    prod_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;

  logic            in_beat;
  logic            k_last;
  logic            skip;
  logic            out_free;
  logic            div_start;
  logic            div_done;
  logic [PctW-1:0] div_quot;
  logic [OutDataW-1:0] res_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign k_last        = (k_q == IdxW'(NumCounters - 1));
  assign skip          = first_q || (total_q == '0);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign div_start     = (state_q == ST_START);

  always_comb begin
    res_data = '0;
    for (int i = 0; i < NumCounters; i++) begin
      res_data[i*PctW +: PctW] = skip ? '0 : pct_q[i];
    end
    res_data[NumCounters*PctW +: CountW] = first_q ? '0 : total_q;
  end

  ctsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      first_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      k_q         <= '0;
      prev_q      <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            first_q     <= !have_prev_q;
            have_prev_q <= 1'b1;
            k_q         <= '0;
            for (int i = 0; i < NumCounters; i++) begin
              prev_q[i] <= s_axis_tdata[i*CountW +: CountW];
            end
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          k_q <= k_q + 1'b1;
          if (k_last) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          k_q     <= '0;
          state_q <= skip ? ST_FIN : ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            k_q     <= k_q + 1'b1;
            state_q <= k_last ? ST_FIN : ST_MUL;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      total_q <= '0;
      for (int i = 0; i < NumCounters; i++) begin
        delta_q[i] <= s_axis_tdata[i*CountW +: CountW] - prev_q[i];
      end
    end
    if (state_q == ST_SUM) begin
      total_q <= total_q + delta_q[k_q];
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(delta_q[k_q]) * ProdW'(PctFull);
    end
    if ((state_q == ST_WAIT) && div_done) begin
      pct_q[k_q] <= div_quot;
    end
    if ((state_q == ST_FIN) && out_free) begin
      m_data_q <= res_data;
      m_user_q <= first_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire
